// ===== hdl/lam_pkg.sv =====
`default_nettype none
package lam_pkg;
	localparam int DATA_W = 32;
	localparam int SQ_W = 64;
	localparam int ROW_W = 2;

	localparam logic [ROW_W-1:0] ROW_SIDE = 2'd0;
	localparam logic [ROW_W-1:0] ROW_UP = 2'd1;
	localparam logic [ROW_W-1:0] ROW_FWD = 2'd2;
	localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;
endpackage
`default_nettype wire

// ===== hdl/lam_isqrt.sv =====
`default_nettype none
module lam_isqrt #(
	parameter int NL = 2,
	parameter int PAY_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [NL-1:0][lam_pkg::SQ_W-1:0] in_rad,
	input  logic [PAY_W-1:0] in_pay,
	output logic out_vld,
	output logic [NL-1:0][lam_pkg::DATA_W-1:0] out_root,
	output logic [PAY_W-1:0] out_pay
);
	import lam_pkg::*;

	localparam int STEPS = SQ_W / 2;

	// One digit of the root per stage; the radicand remainder and partial root travel along.
	logic [SQ_W-1:0] rad_s [STEPS][NL];
	logic [SQ_W-1:0] rt_s [STEPS][NL];
	logic [PAY_W-1:0] pay_s [STEPS];
	logic vld_s [STEPS];

	genvar j, l;
	for (j = 0; j < STEPS; j++) begin : g_step
		logic [SQ_W-1:0] rad_p [NL];
		logic [SQ_W-1:0] rt_p [NL];
		logic [PAY_W-1:0] pay_p;
		logic vld_p;

		if (j == 0) begin : g_first
			for (l = 0; l < NL; l++) begin : g_in
				assign rad_p[l] = in_rad[l];
				assign rt_p[l] = '0;
			end
			assign pay_p = in_pay;
			assign vld_p = in_vld;
		end else begin : g_next
			for (l = 0; l < NL; l++) begin : g_in
				assign rad_p[l] = rad_s[j-1][l];
				assign rt_p[l] = rt_s[j-1][l];
			end
			assign pay_p = pay_s[j-1];
			assign vld_p = vld_s[j-1];
		end

		for (l = 0; l < NL; l++) begin : g_lane
			localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
			logic [SQ_W-1:0] trial;
			logic ge;

			assign trial = rt_p[l] + BIT;
			assign ge = rad_p[l] >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[j][l] <= ge ? rad_p[l] - trial : rad_p[l];
					rt_s[j][l] <= ge ? (rt_p[l] >> 1) + BIT : rt_p[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[j] <= pay_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_p;
			end
		end
	end

	for (l = 0; l < NL; l++) begin : g_out
		assign out_root[l] = rt_s[STEPS-1][l][DATA_W-1:0];
	end
	assign out_pay = pay_s[STEPS-1];
	assign out_vld = vld_s[STEPS-1];
endmodule
`default_nettype wire

// ===== hdl/lam_div.sv =====
`default_nettype none
module lam_div #(
	parameter int FRAC_BITS = 16,
	parameter int NL = 5,
	parameter int PAY_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [NL-1:0][lam_pkg::DATA_W-1:0] in_mag,
	input  logic [NL-1:0][lam_pkg::DATA_W-1:0] in_den,
	input  logic [PAY_W-1:0] in_pay,
	output logic out_vld,
	output logic [NL-1:0][FRAC_BITS:0] out_quo,
	output logic [PAY_W-1:0] out_pay
);
	import lam_pkg::*;

	localparam int STEPS = FRAC_BITS + 1;
	localparam int NW = DATA_W + FRAC_BITS + 1;

	// Restoring division, one quotient bit per stage, most significant first.
	// The magnitude never exceeds the divisor, so the quotient fits FRAC_BITS+1 bits.
	logic [NW-1:0] rem_s [STEPS][NL];
	logic [DATA_W-1:0] den_s [STEPS][NL];
	logic [FRAC_BITS:0] quo_s [STEPS][NL];
	logic [PAY_W-1:0] pay_s [STEPS];
	logic vld_s [STEPS];

	genvar j, l;
	for (j = 0; j < STEPS; j++) begin : g_step
		logic [NW-1:0] rem_p [NL];
		logic [DATA_W-1:0] den_p [NL];
		logic [FRAC_BITS:0] quo_p [NL];
		logic [PAY_W-1:0] pay_p;
		logic vld_p;

		if (j == 0) begin : g_first
			for (l = 0; l < NL; l++) begin : g_in
				assign rem_p[l] = (NW'(in_mag[l]) << FRAC_BITS) + NW'(in_den[l] >> 1);
				assign den_p[l] = in_den[l];
				assign quo_p[l] = '0;
			end
			assign pay_p = in_pay;
			assign vld_p = in_vld;
		end else begin : g_next
			for (l = 0; l < NL; l++) begin : g_in
				assign rem_p[l] = rem_s[j-1][l];
				assign den_p[l] = den_s[j-1][l];
				assign quo_p[l] = quo_s[j-1][l];
			end
			assign pay_p = pay_s[j-1];
			assign vld_p = vld_s[j-1];
		end

		for (l = 0; l < NL; l++) begin : g_lane
			localparam int K = FRAC_BITS - j;
			logic [NW-1:0] dsh;
			logic ge;

			assign dsh = NW'(den_p[l]) << K;
			assign ge = rem_p[l] >= dsh;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j][l] <= ge ? rem_p[l] - dsh : rem_p[l];
					den_s[j][l] <= den_p[l];
					quo_s[j][l] <= quo_p[l] | ((FRAC_BITS + 1)'(ge) << K);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[j] <= pay_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_p;
			end
		end
	end

	for (l = 0; l < NL; l++) begin : g_out
		assign out_quo[l] = quo_s[STEPS-1][l];
	end
	assign out_pay = pay_s[STEPS-1];
	assign out_vld = vld_s[STEPS-1];
endmodule
`default_nettype wire

// ===== hdl/look_at_view_matrix_top.sv =====
`default_nettype none
// Right-handed look-at view matrix in signed fixed point with FRAC_BITS fraction bits.
// Each accepted eye/target pair produces four row transfers (side, up, negated forward,
// then 0 0 0 1), row_index 0 to 3, last_row on the fourth. An eye/target pair whose
// difference has zero x and z gives the identity matrix with degenerate set. The datapath
// is a stalling pipeline of FRAC_BITS+41 stages (three front stages, a 32-stage square
// root, a FRAC_BITS+1 stage divider, four product and rounding stages, one output stage);
// a new pair can enter every cycle while in_ready is high, but each pair leaves as four
// row transfers, and the pipeline stalls while the row sequencer is still sending them.
module look_at_view_matrix_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [lam_pkg::DATA_W-1:0] eye_x,
	input  logic signed [lam_pkg::DATA_W-1:0] eye_y,
	input  logic signed [lam_pkg::DATA_W-1:0] eye_z,
	input  logic signed [lam_pkg::DATA_W-1:0] target_x,
	input  logic signed [lam_pkg::DATA_W-1:0] target_y,
	input  logic signed [lam_pkg::DATA_W-1:0] target_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [lam_pkg::ROW_W-1:0] row_index,
	output logic signed [lam_pkg::DATA_W-1:0] coef_0,
	output logic signed [lam_pkg::DATA_W-1:0] coef_1,
	output logic signed [lam_pkg::DATA_W-1:0] coef_2,
	output logic signed [lam_pkg::DATA_W-1:0] coef_3,
	output logic degenerate,
	output logic last_row
);
	import lam_pkg::*;

	localparam int UW = FRAC_BITS + 3;
	localparam int PW = DATA_W + UW + 3;
	localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [PW-1:0] SMAX = PW'(64'sh7fffffff);
	localparam logic signed [PW-1:0] SMIN = ~SMAX;
	localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic signed [DATA_W-1:0] ex;
		logic signed [DATA_W-1:0] ey;
		logic signed [DATA_W-1:0] ez;
		logic [DATA_W-1:0] mx;
		logic [DATA_W-1:0] my;
		logic [DATA_W-1:0] mz;
		logic nx;
		logic ny;
		logic nz;
		logic degen;
	} sq_pay_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] ex;
		logic signed [DATA_W-1:0] ey;
		logic signed [DATA_W-1:0] ez;
		logic nx;
		logic ny;
		logic nz;
		logic degen;
	} dv_pay_t;

	function automatic logic signed [DATA_W-1:0] sat_diff(input logic signed [DATA_W:0] v);
		if (v[DATA_W] != v[DATA_W-1]) begin
			return v[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
		end
		return v[DATA_W-1:0];
	endfunction

	// Shift right by FRAC_BITS, ties rounded away from zero.
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
		logic [PW-1:0] mag;
		logic [PW-1:0] r;
		mag = v[PW-1] ? PW'(-v) : PW'(v);
		r = (mag + PW'(HALF)) >> FRAC_BITS;
		return v[PW-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat(input logic signed [PW-1:0] v);
		if (v > SMAX) begin
			return DATA_W'(SMAX);
		end
		if (v < SMIN) begin
			return DATA_W'(SMIN);
		end
		return DATA_W'(v);
	endfunction

	logic en;
	logic ld;
	logic free;

	// Front stages: differences, squares, sums.
	logic signed [DATA_W-1:0] eye [3];
	logic signed [DATA_W-1:0] tgt [3];
	logic signed [DATA_W-1:0] d_s1 [3];
	logic signed [DATA_W-1:0] e_s1 [3];
	logic vld_s1;
	logic [SQ_W-1:0] sq_s2 [3];
	sq_pay_t pay_s2;
	logic vld_s2;
	logic [SQ_W-1:0] sumf_s3;
	logic [SQ_W-1:0] sums_s3;
	sq_pay_t pay_s3;
	logic vld_s3;

	assign eye[0] = eye_x;
	assign eye[1] = eye_y;
	assign eye[2] = eye_z;
	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;
	assign in_ready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= sat_diff((DATA_W + 1)'(tgt[i]) - (DATA_W + 1)'(eye[i]));
				e_s1[i] <= eye[i];
			end
		end
	end

	logic signed [SQ_W-1:0] sqr [3];
	logic [DATA_W-1:0] mag [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqr[i] = d_s1[i] * d_s1[i];
			mag[i] = d_s1[i][DATA_W-1] ? DATA_W'(-d_s1[i]) : DATA_W'(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SQ_W'(sqr[i]);
			end
			pay_s2.ex <= e_s1[0];
			pay_s2.ey <= e_s1[1];
			pay_s2.ez <= e_s1[2];
			pay_s2.mx <= mag[0];
			pay_s2.my <= mag[1];
			pay_s2.mz <= mag[2];
			pay_s2.nx <= d_s1[0][DATA_W-1];
			pay_s2.ny <= d_s1[1][DATA_W-1];
			pay_s2.nz <= d_s1[2][DATA_W-1];
			// Zero x and z means either a zero forward or forward along the up axis.
			pay_s2.degen <= (d_s1[0] == '0) && (d_s1[2] == '0);
			sumf_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sums_s3 <= sq_s2[0] + sq_s2[2];
			pay_s3 <= pay_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Vector lengths.
	logic sq_vld;
	logic [1:0][DATA_W-1:0] root;
	sq_pay_t sq_pay;

	lam_isqrt #(
		.NL(2),
		.PAY_W($bits(sq_pay_t))
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s3),
		.in_rad({sums_s3, sumf_s3}),
		.in_pay(pay_s3),
		.out_vld(sq_vld),
		.out_root(root),
		.out_pay(sq_pay)
	);

	// Unit components: lanes fx, fy, fz over the forward length, sx, sz over the side length.
	logic dv_vld;
	logic [4:0][FRAC_BITS:0] quo;
	dv_pay_t dv_in;
	dv_pay_t dv_pay;

	assign dv_in.ex = sq_pay.ex;
	assign dv_in.ey = sq_pay.ey;
	assign dv_in.ez = sq_pay.ez;
	assign dv_in.nx = sq_pay.nx;
	assign dv_in.ny = sq_pay.ny;
	assign dv_in.nz = sq_pay.nz;
	assign dv_in.degen = sq_pay.degen;

	lam_div #(
		.FRAC_BITS(FRAC_BITS),
		.NL(5),
		.PAY_W($bits(dv_pay_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(sq_vld),
		.in_mag({sq_pay.mx, sq_pay.mz, sq_pay.mz, sq_pay.my, sq_pay.mx}),
		.in_den({root[1], root[1], root[0], root[0], root[0]}),
		.in_pay(dv_in),
		.out_vld(dv_vld),
		.out_quo(quo),
		.out_pay(dv_pay)
	);

	logic signed [UW-1:0] fx;
	logic signed [UW-1:0] fy;
	logic signed [UW-1:0] fz;
	logic signed [UW-1:0] sx;
	logic signed [UW-1:0] sz;

	// The side direction is (-dz, 0, dx).
	assign fx = dv_pay.nx ? -UW'(quo[0]) : UW'(quo[0]);
	assign fy = dv_pay.ny ? -UW'(quo[1]) : UW'(quo[1]);
	assign fz = dv_pay.nz ? -UW'(quo[2]) : UW'(quo[2]);
	assign sx = dv_pay.nz ? UW'(quo[3]) : -UW'(quo[3]);
	assign sz = dv_pay.nx ? -UW'(quo[4]) : UW'(quo[4]);

	// Products of unit components, and with the eye point.
	logic signed [PW-1:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic signed [PW-1:0] m0_s4, m1_s4, m2_s4, m3_s4, m4_s4;
	logic signed [UW-1:0] fx_s4, fy_s4, fz_s4, sx_s4, sz_s4;
	dv_pay_t pay_s4;
	logic vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4 <= sz * fy;
			pb_s4 <= sz * fx;
			pc_s4 <= sx * fz;
			pd_s4 <= sx * fy;
			m0_s4 <= sx * dv_pay.ex;
			m1_s4 <= sz * dv_pay.ez;
			m2_s4 <= fx * dv_pay.ex;
			m3_s4 <= fy * dv_pay.ey;
			m4_s4 <= fz * dv_pay.ez;
			fx_s4 <= fx;
			fy_s4 <= fy;
			fz_s4 <= fz;
			sx_s4 <= sx;
			sz_s4 <= sz;
			pay_s4 <= dv_pay;
		end
	end

	// Up vector and the side and forward translations.
	logic signed [UW-1:0] ux_s5, uy_s5, uz_s5;
	logic signed [DATA_W-1:0] t0_s5, t2_s5;
	logic signed [UW-1:0] fx_s5, fy_s5, fz_s5, sx_s5, sz_s5;
	dv_pay_t pay_s5;
	logic vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s5 <= UW'(rnd(-pa_s4));
			uy_s5 <= UW'(rnd(pb_s4 - pc_s4));
			uz_s5 <= UW'(rnd(pd_s4));
			t0_s5 <= sat(rnd(-(m0_s4 + m1_s4)));
			t2_s5 <= sat(rnd(m2_s4 + m3_s4 + m4_s4));
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			sx_s5 <= sx_s4;
			sz_s5 <= sz_s4;
			pay_s5 <= pay_s4;
		end
	end

	logic signed [PW-1:0] n0_s6, n1_s6, n2_s6;
	logic signed [UW-1:0] ux_s6, uy_s6, uz_s6;
	logic signed [DATA_W-1:0] t0_s6, t2_s6;
	logic signed [UW-1:0] fx_s6, fy_s6, fz_s6, sx_s6, sz_s6;
	logic degen_s6;
	logic vld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s6 <= ux_s5 * pay_s5.ex;
			n1_s6 <= uy_s5 * pay_s5.ey;
			n2_s6 <= uz_s5 * pay_s5.ez;
			ux_s6 <= ux_s5;
			uy_s6 <= uy_s5;
			uz_s6 <= uz_s5;
			t0_s6 <= t0_s5;
			t2_s6 <= t2_s5;
			fx_s6 <= fx_s5;
			fy_s6 <= fy_s5;
			fz_s6 <= fz_s5;
			sx_s6 <= sx_s5;
			sz_s6 <= sz_s5;
			degen_s6 <= pay_s5.degen;
		end
	end

	logic signed [DATA_W-1:0] t1_s7;
	logic signed [UW-1:0] ux_s7, uy_s7, uz_s7;
	logic signed [DATA_W-1:0] t0_s7, t2_s7;
	logic signed [UW-1:0] fx_s7, fy_s7, fz_s7, sx_s7, sz_s7;
	logic degen_s7;
	logic vld_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s7 <= sat(rnd(-(n0_s6 + n1_s6 + n2_s6)));
			ux_s7 <= ux_s6;
			uy_s7 <= uy_s6;
			uz_s7 <= uz_s6;
			t0_s7 <= t0_s6;
			t2_s7 <= t2_s6;
			fx_s7 <= fx_s6;
			fy_s7 <= fy_s6;
			fz_s7 <= fz_s6;
			sx_s7 <= sx_s6;
			sz_s7 <= sz_s6;
			degen_s7 <= degen_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= dv_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Row sequencer: holds one finished matrix and sends it as four transfers.
	logic ser_vld_q;
	logic [ROW_W-1:0] row_q;
	logic signed [UW-1:0] ux_q, uy_q, uz_q, fx_q, fy_q, fz_q, sx_q, sz_q;
	logic signed [DATA_W-1:0] t0_q, t1_q, t2_q;
	logic degen_q;

	assign free = !ser_vld_q || (out_ready && (row_q == ROW_LAST));
	assign ld = vld_s7 && free;
	assign en = !vld_s7 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			row_q <= ROW_SIDE;
		end else if (ld) begin
			ser_vld_q <= 1'b1;
			row_q <= ROW_SIDE;
		end else if (ser_vld_q && out_ready) begin
			if (row_q == ROW_LAST) begin
				ser_vld_q <= 1'b0;
			end
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ux_q <= ux_s7;
			uy_q <= uy_s7;
			uz_q <= uz_s7;
			fx_q <= fx_s7;
			fy_q <= fy_s7;
			fz_q <= fz_s7;
			sx_q <= sx_s7;
			sz_q <= sz_s7;
			t0_q <= t0_s7;
			t1_q <= t1_s7;
			t2_q <= t2_s7;
			degen_q <= degen_s7;
		end
	end

	assign out_valid = ser_vld_q;
	assign row_index = row_q;
	assign degenerate = degen_q;
	assign last_row = row_q == ROW_LAST;

	always_comb begin
		coef_0 = '0;
		coef_1 = '0;
		coef_2 = '0;
		coef_3 = '0;
		if (degen_q) begin
			unique case (row_q)
				ROW_SIDE: coef_0 = ONE;
				ROW_UP: coef_1 = ONE;
				ROW_FWD: coef_2 = ONE;
				default: coef_3 = ONE;
			endcase
		end else begin
			unique case (row_q)
				ROW_SIDE: begin
					coef_0 = DATA_W'(sx_q);
					coef_2 = DATA_W'(sz_q);
					coef_3 = t0_q;
				end
				ROW_UP: begin
					coef_0 = DATA_W'(ux_q);
					coef_1 = DATA_W'(uy_q);
					coef_2 = DATA_W'(uz_q);
					coef_3 = t1_q;
				end
				ROW_FWD: begin
					coef_0 = -DATA_W'(fx_q);
					coef_1 = -DATA_W'(fy_q);
					coef_2 = -DATA_W'(fz_q);
					coef_3 = t2_q;
				end
				default: coef_3 = ONE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import lam_pkg::*;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [31:0] c0, c1, c2, c3;
		logic degen;
		logic last;
	} view_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
	logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ROW_W-1:0] row_index;
	logic signed [31:0] coef_0, coef_1, coef_2, coef_3;
	logic degenerate, last_row;

	view_row_t rows_due[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_enable = 1'b1;

	look_at_view_matrix_top #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .coef_0(coef_0), .coef_1(coef_1), .coef_2(coef_2),
		.coef_3(coef_3), .degenerate(degenerate), .last_row(last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_shift(longint v);
		longint unsigned mag = (v < 0) ? -v : v;
		longint r = longint'((mag + (64'd1 << (FRAC - 1))) >> FRAC);
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint unit_part(longint num, longint unsigned len);
		longint unsigned mag = (num < 0) ? -num : num;
		longint unsigned q = ((mag << FRAC) + len / 2) / len;
		if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic view_row_t make_row(int k, longint a, longint b, longint c,
			longint d, bit dg);
		view_row_t r;
		r.row = k[ROW_W-1:0];
		r.c0 = a[31:0];
		r.c1 = b[31:0];
		r.c2 = c[31:0];
		r.c3 = d[31:0];
		r.degen = dg;
		r.last = (k == 3);
		return r;
	endfunction

	// Pushes the four rows of the view matrix for one eye/target pair.
	task automatic predict_view(longint ex, longint ey, longint ez,
			longint tx, longint ty, longint tz);
		longint dx, dy, dz, fx, fy, fz, sx, sz, ux, uy, uz;
		longint unsigned qx, qy, qz, flen, slen;
		dx = clip32(tx - ex);
		dy = clip32(ty - ey);
		dz = clip32(tz - ez);
		qx = dx * dx;
		qy = dy * dy;
		qz = dz * dz;
		flen = int_sqrt(qx + qy + qz);
		slen = int_sqrt(qx + qz);
		if (flen == 0 || slen == 0) begin
			rows_due.push_back(make_row(0, ONE, 0, 0, 0, 1));
			rows_due.push_back(make_row(1, 0, ONE, 0, 0, 1));
			rows_due.push_back(make_row(2, 0, 0, ONE, 0, 1));
			rows_due.push_back(make_row(3, 0, 0, 0, ONE, 1));
			return;
		end
		fx = unit_part(dx, flen);
		fy = unit_part(dy, flen);
		fz = unit_part(dz, flen);
		sx = unit_part(-dz, slen);
		sz = unit_part(dx, slen);
		ux = round_shift(-(sz * fy));
		uy = round_shift(sz * fx - sx * fz);
		uz = round_shift(sx * fy);
		rows_due.push_back(make_row(0, sx, 0, sz,
			clip32(round_shift(-(sx * ex + sz * ez))), 0));
		rows_due.push_back(make_row(1, ux, uy, uz,
			clip32(round_shift(-(ux * ex + uy * ey + uz * ez))), 0));
		rows_due.push_back(make_row(2, -fx, -fy, -fz,
			clip32(round_shift(fx * ex + fy * ey + fz * ez)), 0));
		rows_due.push_back(make_row(3, 0, 0, 0, ONE, 0));
	endtask

	// Drives one pair and holds it until the transfer; prediction happens on acceptance.
	// Valid stays high afterward so that pairs can follow back to back; idle_input drops it.
	task automatic send_pair(logic signed [31:0] ex, ey, ez, tx, ty, tz);
		eye_x <= ex; eye_y <= ey; eye_z <= ez;
		target_x <= tx; target_y <= ty; target_z <= tz;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_view(ex, ey, ez, tx, ty, tz);
		@(negedge clk);
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
				: 32'h8000_0000 + $urandom_range(0, 15);
			default: return $urandom_range(0, 32'h0FFF) - 32'h0800;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			view_row_t want;
			if (rows_due.size() == 0) begin
				$display("%0t unexpected row: row %0d coefs %h %h %h %h", $time,
					row_index, coef_0, coef_1, coef_2, coef_3);
				errors++;
			end else begin
				want = rows_due.pop_front();
				if (want.row !== row_index) begin
					$display("%0t row_index expected %0d actual %0d", $time, want.row, row_index);
					errors++;
				end
				if (want.c0 !== coef_0) begin
					$display("%0t coef_0 expected %h actual %h", $time, want.c0, coef_0);
					errors++;
				end
				if (want.c1 !== coef_1) begin
					$display("%0t coef_1 expected %h actual %h", $time, want.c1, coef_1);
					errors++;
				end
				if (want.c2 !== coef_2) begin
					$display("%0t coef_2 expected %h actual %h", $time, want.c2, coef_2);
					errors++;
				end
				if (want.c3 !== coef_3) begin
					$display("%0t coef_3 expected %h actual %h", $time, want.c3, coef_3);
					errors++;
				end
				if (want.degen !== degenerate) begin
					$display("%0t degenerate expected %b actual %b", $time, want.degen,
						degenerate);
					errors++;
				end
				if (want.last !== last_row) begin
					$display("%0t last_row expected %b actual %b", $time, want.last, last_row);
					errors++;
				end
			end
		end
	end

	// While stall_enable is set, the receiver stalls on its own pattern: long open stretches, then bursts of stalls.
	always @(negedge clk) begin
		if (!stall_enable)
			out_ready <= 1'b1;
		else if (($time / 1000) % 3 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic test_degenerate();
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		send_pair(5, -7, 9, 5, 100, 9);
		send_pair(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0);
	endtask

	task automatic test_extremes();
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send_pair(0, 0, 0, 1, 0, 0);
		send_pair(0, 0, 0, 0, 0, -1);
		send_pair(0, 0, 0, 1, 1, 1);
		send_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);
		send_pair(0, 0, 0, 1, 32'h7FFF_FFFF, 0);
		send_pair(32'h7FFF_0000, 0, 32'h8001_0000, 32'h7FFF_0001, 0, 32'h8001_0000);
		idle_input();
	endtask

	task automatic test_random();
		int sent = 0;
		int burst, mode, pick;
		logic [31:0] ex, ey, ez, tx, ty, tz;
		while (sent < 410) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				mode = $urandom_range(0, 3);
				ex = rand_coord(mode); ey = rand_coord(mode); ez = rand_coord(mode);
				tx = rand_coord(mode); ty = rand_coord(mode); tz = rand_coord(mode);
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					tx = ex; ty = ey; tz = ez;
				end else if (pick == 1) begin
					tx = ex; tz = ez;
				end else if (pick == 2) begin
					tx = ex + $urandom_range(0, 2) - 1;
					tz = ez + $urandom_range(0, 2) - 1;
				end
				send_pair(ex, ey, ez, tx, ty, tz);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				idle_input();
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
		idle_input();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		stall_enable = 1'b0;
		test_degenerate();
		test_extremes();
		stall_enable = 1'b1;
		test_random();
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && rows_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
